>>> sv/cre_pkg.sv
// Shared types and constants for the crossover response evaluator.
// No dependencies; every other file in this block imports this package.
package cre_pkg;

    localparam int CRE_CUTOFF_W = 20;
    localparam int CRE_ORDER_W  = 3;
    localparam int CRE_ALIGN_W  = 2;
    localparam int CRE_Q_W      = 10;
    localparam int CRE_DIGIT_W  = 16;
    localparam int CRE_RES_W    = 32;
    localparam int CRE_DATA_W   = 32;
    localparam int CRE_ADDR_W   = 4;

    // damping term scale: q = 1000 * Q
    localparam int CRE_DAMP_SCALE = 1000;

    localparam logic [CRE_Q_W-1:0] CRE_Q_LR     = 10'd500;
    localparam logic [CRE_Q_W-1:0] CRE_Q_BUTTER = 10'd707;
    localparam logic [CRE_Q_W-1:0] CRE_Q_BESSEL = 10'd577;

    localparam logic [CRE_ORDER_W-1:0] CRE_ORDER_1 = 3'd1;
    localparam logic [CRE_ORDER_W-1:0] CRE_ORDER_2 = 3'd2;
    localparam logic [CRE_ORDER_W-1:0] CRE_ORDER_3 = 3'd3;
    localparam logic [CRE_ORDER_W-1:0] CRE_ORDER_4 = 3'd4;

    localparam logic [CRE_ALIGN_W-1:0] CRE_ALIGN_LR     = 2'd0;
    localparam logic [CRE_ALIGN_W-1:0] CRE_ALIGN_BESSEL = 2'd2;

    localparam logic CRE_PASS_LOW = 1'b1;

    localparam logic [CRE_CUTOFF_W-1:0] CRE_CUTOFF_RST = 20'd6283;
    localparam logic [CRE_ORDER_W-1:0]  CRE_ORDER_RST  = 3'd2;
    localparam logic                    CRE_PASS_RST   = 1'b0;
    localparam logic [CRE_ALIGN_W-1:0]  CRE_ALIGN_RST  = 2'd0;

    localparam logic [CRE_RES_W-1:0] CRE_RES_MAX = 32'h7FFF_FFFF;
    localparam logic [CRE_RES_W-1:0] CRE_RES_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        CRE_REG_CUTOFF,
        CRE_REG_ORDER,
        CRE_REG_PASS,
        CRE_REG_ALIGN
    } cre_reg_t;

endpackage

>>> sv/cre_mul.sv
// Pipelined signed multiplier: one 16-bit digit of b per stage.
// Depends on cre_pkg for the digit width.
module cre_mul
    import cre_pkg::*;
#(
    parameter int AW = 16,
    parameter int BW = 16
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);
    localparam int DW = CRE_DIGIT_W;
    localparam int ND = (BW + DW - 1) / DW;
    localparam int BP = ND * DW;
    localparam int PW = AW + BP;

    logic signed [AW-1:0] a_reg   [ND];
    logic signed [BP-1:0] b_reg   [ND];
    logic signed [PW-1:0] acc_reg [ND];

    for (genvar i = 0; i < ND; i++)
    begin : g_stg
        logic signed [AW-1:0]   a_in;
        logic signed [BP-1:0]   b_in;
        logic signed [PW-1:0]   acc_in;
        logic signed [DW:0]     dig;
        logic signed [AW+DW:0]  part;
        logic signed [PW-1:0]   acc_next;

        if (i == 0)
        begin : g_head
            assign a_in   = a;
            assign b_in   = BP'(b);
            assign acc_in = '0;
        end
        else
        begin : g_tail
            assign a_in   = a_reg[i-1];
            assign b_in   = b_reg[i-1];
            assign acc_in = acc_reg[i-1];
        end

        // top digit carries the sign, lower digits are unsigned
        if (i == ND - 1)
        begin : g_msd
            assign dig = {b_in[BP-1], b_in[i*DW +: DW]};
        end
        else
        begin : g_lsd
            assign dig = {1'b0, b_in[i*DW +: DW]};
        end

        assign part     = a_in * dig;
        assign acc_next = acc_in + (PW'(part) <<< (i * DW));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg[i]   <= a_in;
                b_reg[i]   <= b_in;
                acc_reg[i] <= acc_next;
            end
        end
    end

    assign p = acc_reg[ND-1][AW+BW-1:0];

endmodule

>>> sv/cre_delay.sv
// Stallable delay line that keeps operands aligned with multiplier stages.
// Depends on cre_pkg only by convention of the block.
module cre_delay
    import cre_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 1
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);
    logic [W-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule

>>> sv/cre_div.sv
// Pipelined restoring divider: rounds x/m to a clipped 32-bit fixed-point value.
// One quotient bit per stage after a setup stage. Depends on cre_pkg.
module cre_div
    import cre_pkg::*;
#(
    parameter int XW = 64,
    parameter int FB = 30
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [XW-1:0] x,
    input  logic [XW-1:0]        m,
    output logic [CRE_RES_W-1:0] q,
    output logic                 sat
);
    localparam int QW = CRE_RES_W;
    localparam int RW = XW + FB + QW + 4;

    logic [RW-1:0] rem_reg [QW];
    logic [RW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW+1];
    logic          neg_reg [QW+1];
    logic          ovf_reg [QW+1];
    logic          pole_reg [QW+1];

    logic          neg0;
    logic [XW-1:0] mag0;
    logic [RW-1:0] num0;
    logic [RW-1:0] den0;
    logic          ovf0;
    logic          pole0;

    // setup: 2*|x|*2^FB + m over 2*m gives round half away from zero
    assign neg0  = x[XW-1];
    assign mag0  = neg0 ? XW'(~x + 1'b1) : XW'(x);
    assign num0  = (RW'(mag0) << (FB + 1)) + RW'(m);
    assign den0  = RW'(m) << 1;
    assign ovf0  = num0 >= (den0 << QW);
    assign pole0 = (m == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num0;
            den_reg[0]  <= den0;
            quo_reg[0]  <= '0;
            neg_reg[0]  <= neg0;
            ovf_reg[0]  <= ovf0;
            pole_reg[0] <= pole0;
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_bit
        logic [RW-1:0] trial;
        logic          ge;

        assign trial = den_reg[k-1] << (QW - k);
        assign ge    = rem_reg[k-1] >= trial;

        if (k < QW)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? (rem_reg[k-1] - trial) : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k]  <= {quo_reg[k-1][QW-2:0], ge};
                neg_reg[k]  <= neg_reg[k-1];
                ovf_reg[k]  <= ovf_reg[k-1];
                pole_reg[k] <= pole_reg[k-1];
            end
        end
    end

    // apply sign and clip to the signed range; a zero divisor gives zero with sat set
    always_comb
    begin
        q   = '0;
        sat = 1'b0;
        if (pole_reg[QW])
        begin
            sat = 1'b1;
        end
        else if (ovf_reg[QW])
        begin
            sat = 1'b1;
            q   = neg_reg[QW] ? CRE_RES_MIN : CRE_RES_MAX;
        end
        else if (!neg_reg[QW])
        begin
            if (quo_reg[QW] > CRE_RES_MAX)
            begin
                sat = 1'b1;
                q   = CRE_RES_MAX;
            end
            else
            begin
                q = quo_reg[QW];
            end
        end
        else
        begin
            if (quo_reg[QW] > CRE_RES_MIN)
            begin
                sat = 1'b1;
                q   = CRE_RES_MIN;
            end
            else
            begin
                q = ~quo_reg[QW] + 1'b1;
            end
        end
    end

endmodule

>>> sv/crossover_response_eval.sv
// Crossover response evaluator top level: APB register file and the full pipeline.
// Depends on cre_pkg, cre_mul, cre_delay and cre_div.
//
// Usage: each request on the eval channel (eval_valid/eval_ready) carries one
// complex frequency s = s_real + j*s_imag in rad/s. The block answers with
// H(s) of the configured crossover on the resp channel (resp_valid/resp_ready):
// h_real and h_imag in signed fixed point with RESULT_FRAC_BITS fraction bits,
// and saturated when either part was clipped or s hit a pole.
// Write cutoff, filter_order, pass_select and alignment over APB (byte address
// 4 * register index) only while no request is in flight.
// The pipeline depth is set by the two digit-serial multiplier banks (order-4 squaring
// and the final conjugate products) and the 33-stage quotient pipeline.
// Throughput: one request per cycle while the receiver does not stall.
// Reset: the pipeline empties and the registers return to 6283 rad/s,
// second order, high pass, Linkwitz-Riley.
// Stall: while resp_valid is high and resp_ready low, every stage holds and
// eval_ready drops; nothing is lost or repeated.
module crossover_response_eval
    import cre_pkg::*;
#(
    parameter int FREQ_WIDTH       = 21,
    parameter int RESULT_FRAC_BITS = 30
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CRE_ADDR_W-1:0]         paddr,
    input  logic [CRE_DATA_W-1:0]         pwdata,
    output logic [CRE_DATA_W-1:0]         prdata,
    output logic                          pready,
    input  logic                          eval_valid,
    output logic                          eval_ready,
    input  logic signed [FREQ_WIDTH-1:0]  s_real,
    input  logic signed [FREQ_WIDTH-1:0]  s_imag,
    output logic                          resp_valid,
    input  logic                          resp_ready,
    output logic signed [CRE_RES_W-1:0]   h_real,
    output logic signed [CRE_RES_W-1:0]   h_imag,
    output logic                          saturated
);
    localparam int FW  = FREQ_WIDTH;
    localparam int CW  = CRE_CUTOFF_W;
    localparam int QW  = CRE_Q_W;
    localparam int S2W = 2 * FW + 1;
    localparam int S3W = 3 * FW + 2;
    localparam int NW  = ((3 * FW > 60) ? 3 * FW : 60) + 4;
    localparam int SW  = 2 * NW + 2;
    localparam int XW  = 2 * SW + 1;
    localparam int L4  = (NW + CRE_DIGIT_W - 1) / CRE_DIGIT_W;
    localparam int L5  = (SW + CRE_DIGIT_W - 1) / CRE_DIGIT_W;
    localparam int TOT = 39 + L4 + L5;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CW-1:0]          cutoff_reg;
    logic [CRE_ORDER_W-1:0] order_reg;
    logic                   pass_reg;
    logic [CRE_ALIGN_W-1:0] align_reg;
    logic                   wr_en;
    cre_reg_t               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = cre_reg_t'(paddr[CRE_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= CRE_CUTOFF_RST;
            order_reg  <= CRE_ORDER_RST;
            pass_reg   <= CRE_PASS_RST;
            align_reg  <= CRE_ALIGN_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                CRE_REG_CUTOFF: cutoff_reg <= pwdata[CW-1:0];
                CRE_REG_ORDER:  order_reg  <= pwdata[CRE_ORDER_W-1:0];
                CRE_REG_PASS:   pass_reg   <= pwdata[0];
                CRE_REG_ALIGN:  align_reg  <= pwdata[CRE_ALIGN_W-1:0];
                default:        cutoff_reg <= cutoff_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            CRE_REG_CUTOFF: prdata = CRE_DATA_W'(cutoff_reg);
            CRE_REG_ORDER:  prdata = CRE_DATA_W'(order_reg);
            CRE_REG_PASS:   prdata = CRE_DATA_W'(pass_reg);
            CRE_REG_ALIGN:  prdata = CRE_DATA_W'(align_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Flow control: the whole pipeline advances together; it holds only
    // when the output register is full and the receiver stalls.
    // ---------------------------------------------------------------
    logic           en;
    logic [TOT-1:0] vld_reg;

    assign en         = !vld_reg[TOT-1] || resp_ready;
    assign eval_ready = en;
    assign resp_valid = vld_reg[TOT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOT-2:0], eval_valid};
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: s squared and cutoff squared
    // ---------------------------------------------------------------
    logic signed [S2W-1:0] sre_x;
    logic signed [S2W-1:0] sim_x;
    logic signed [FW-1:0]  s_re1_reg;
    logic signed [FW-1:0]  s_im1_reg;
    logic signed [S2W-1:0] s2_re1_reg;
    logic signed [S2W-1:0] s2_im1_reg;
    logic [2*CW-1:0]       w2_1_reg;

    assign sre_x = S2W'(s_real);
    assign sim_x = S2W'(s_imag);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_re1_reg  <= s_real;
            s_im1_reg  <= s_imag;
            s2_re1_reg <= sre_x * sre_x - sim_x * sim_x;
            s2_im1_reg <= (sre_x * sim_x) <<< 1;
            w2_1_reg   <= cutoff_reg * cutoff_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: every product term of the order-2 and order-3 forms
    // ---------------------------------------------------------------
    logic [QW-1:0]             q_val;
    logic signed [QW:0]        q_s;
    logic signed [CW:0]        w_s;
    logic signed [2*CW:0]      w2_s;
    logic signed [S2W+FW-1:0]  p_rr;
    logic signed [S2W+FW-1:0]  p_ii;
    logic signed [S2W+FW-1:0]  p_ri;
    logic signed [S2W+FW-1:0]  p_ir;

    logic signed [FW-1:0]       s_re2_reg;
    logic signed [FW-1:0]       s_im2_reg;
    logic signed [S3W-1:0]      s3_re2_reg;
    logic signed [S3W-1:0]      s3_im2_reg;
    logic [3*CW-1:0]            w3_2_reg;
    logic signed [S2W+QW:0]     qs2_re2_reg;
    logic signed [S2W+QW:0]     qs2_im2_reg;
    logic signed [FW+CW:0]      ws_re2_reg;
    logic signed [FW+CW:0]      ws_im2_reg;
    logic signed [S2W+CW:0]     ws2_re2_reg;
    logic signed [S2W+CW:0]     ws2_im2_reg;
    logic signed [FW+2*CW:0]    w2s_re2_reg;
    logic signed [FW+2*CW:0]    w2s_im2_reg;
    logic [2*CW+QW-1:0]         qw2_2_reg;

    always_comb
    begin
        case (align_reg)
            CRE_ALIGN_LR:     q_val = CRE_Q_LR;
            CRE_ALIGN_BESSEL: q_val = CRE_Q_BESSEL;
            default:          q_val = CRE_Q_BUTTER;
        endcase
    end

    assign q_s  = $signed({1'b0, q_val});
    assign w_s  = $signed({1'b0, cutoff_reg});
    assign w2_s = $signed({1'b0, w2_1_reg});
    assign p_rr = s2_re1_reg * s_re1_reg;
    assign p_ii = s2_im1_reg * s_im1_reg;
    assign p_ri = s2_re1_reg * s_im1_reg;
    assign p_ir = s2_im1_reg * s_re1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_re2_reg   <= s_re1_reg;
            s_im2_reg   <= s_im1_reg;
            s3_re2_reg  <= S3W'(p_rr) - S3W'(p_ii);
            s3_im2_reg  <= S3W'(p_ri) + S3W'(p_ir);
            w3_2_reg    <= w2_1_reg * cutoff_reg;
            qs2_re2_reg <= s2_re1_reg * q_s;
            qs2_im2_reg <= s2_im1_reg * q_s;
            ws_re2_reg  <= s_re1_reg * w_s;
            ws_im2_reg  <= s_im1_reg * w_s;
            ws2_re2_reg <= s2_re1_reg * w_s;
            ws2_im2_reg <= s2_im1_reg * w_s;
            w2s_re2_reg <= s_re1_reg * w2_s;
            w2s_im2_reg <= s_im1_reg * w2_s;
            qw2_2_reg   <= w2_1_reg * q_val;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: assemble numerator and denominator for the chosen order
    // ---------------------------------------------------------------
    logic signed [NW-1:0] e_sr, e_si, e_w, e_s3r, e_s3i, e_w3;
    logic signed [NW-1:0] e_qs2r, e_qs2i, e_wsr, e_wsi;
    logic signed [NW-1:0] e_ws2r, e_ws2i, e_w2sr, e_w2si, e_qw2;
    logic signed [NW-1:0] nr3_next, ni3_next, dr3_next, di3_next;
    logic signed [NW-1:0] nr3_reg, ni3_reg, dr3_reg, di3_reg;
    logic                 lp;

    assign lp     = (pass_reg == CRE_PASS_LOW);
    assign e_sr   = NW'(s_re2_reg);
    assign e_si   = NW'(s_im2_reg);
    assign e_w    = NW'($signed({1'b0, cutoff_reg}));
    assign e_s3r  = NW'(s3_re2_reg);
    assign e_s3i  = NW'(s3_im2_reg);
    assign e_w3   = NW'($signed({1'b0, w3_2_reg}));
    assign e_qs2r = NW'(qs2_re2_reg);
    assign e_qs2i = NW'(qs2_im2_reg);
    assign e_wsr  = NW'(ws_re2_reg);
    assign e_wsi  = NW'(ws_im2_reg);
    assign e_ws2r = NW'(ws2_re2_reg);
    assign e_ws2i = NW'(ws2_im2_reg);
    assign e_w2sr = NW'(w2s_re2_reg);
    assign e_w2si = NW'(w2s_im2_reg);
    assign e_qw2  = NW'($signed({1'b0, qw2_2_reg}));

    always_comb
    begin
        case (order_reg)
            CRE_ORDER_2, CRE_ORDER_4:
            begin
                // q*s^2 + 1000*w*s + q*w^2
                dr3_next = e_qs2r + e_wsr * NW'(CRE_DAMP_SCALE) + e_qw2;
                di3_next = e_qs2i + e_wsi * NW'(CRE_DAMP_SCALE);
                nr3_next = lp ? e_qw2 : e_qs2r;
                ni3_next = lp ? '0 : e_qs2i;
            end
            CRE_ORDER_3:
            begin
                // s^3 + 2w*s^2 + 2w^2*s + w^3
                dr3_next = e_s3r + (e_ws2r <<< 1) + (e_w2sr <<< 1) + e_w3;
                di3_next = e_s3i + (e_ws2i <<< 1) + (e_w2si <<< 1);
                nr3_next = lp ? e_w3 : e_s3r;
                ni3_next = lp ? '0 : e_s3i;
            end
            default:
            begin
                // first order; unknown orders fall back to the high pass
                dr3_next = e_sr + e_w;
                di3_next = e_si;
                if (order_reg == CRE_ORDER_1 && lp)
                begin
                    nr3_next = e_w;
                    ni3_next = '0;
                end
                else
                begin
                    nr3_next = e_sr;
                    ni3_next = e_si;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nr3_reg <= nr3_next;
            ni3_reg <= ni3_next;
            dr3_reg <= dr3_next;
            di3_reg <= di3_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: square numerator and denominator for the fourth order;
    // hold the unsquared values alongside through a matching delay.
    // ---------------------------------------------------------------
    logic signed [2*NW-1:0] n_rr, n_ii, n_ri, d_rr, d_ii, d_ri;
    logic [4*NW-1:0]        held3;
    logic signed [NW-1:0]   nr3d, ni3d, dr3d, di3d;
    logic signed [SW-1:0]   nr4_reg, ni4_reg, dr4_reg, di4_reg;

    cre_mul #(.AW(NW), .BW(NW)) u_mul_nrr (.clk(clk), .en(en), .a(nr3_reg), .b(nr3_reg), .p(n_rr));
    cre_mul #(.AW(NW), .BW(NW)) u_mul_nii (.clk(clk), .en(en), .a(ni3_reg), .b(ni3_reg), .p(n_ii));
    cre_mul #(.AW(NW), .BW(NW)) u_mul_nri (.clk(clk), .en(en), .a(nr3_reg), .b(ni3_reg), .p(n_ri));
    cre_mul #(.AW(NW), .BW(NW)) u_mul_drr (.clk(clk), .en(en), .a(dr3_reg), .b(dr3_reg), .p(d_rr));
    cre_mul #(.AW(NW), .BW(NW)) u_mul_dii (.clk(clk), .en(en), .a(di3_reg), .b(di3_reg), .p(d_ii));
    cre_mul #(.AW(NW), .BW(NW)) u_mul_dri (.clk(clk), .en(en), .a(dr3_reg), .b(di3_reg), .p(d_ri));

    cre_delay #(.W(4 * NW), .DEPTH(L4)) u_hold3
    (
        .clk  (clk),
        .en   (en),
        .din  ({nr3_reg, ni3_reg, dr3_reg, di3_reg}),
        .dout (held3)
    );

    assign nr3d = held3[4*NW-1:3*NW];
    assign ni3d = held3[3*NW-1:2*NW];
    assign dr3d = held3[2*NW-1:NW];
    assign di3d = held3[NW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (order_reg == CRE_ORDER_4)
            begin
                nr4_reg <= SW'(n_rr) - SW'(n_ii);
                ni4_reg <= SW'(n_ri) <<< 1;
                dr4_reg <= SW'(d_rr) - SW'(d_ii);
                di4_reg <= SW'(d_ri) <<< 1;
            end
            else
            begin
                nr4_reg <= SW'(nr3d);
                ni4_reg <= SW'(ni3d);
                dr4_reg <= SW'(dr3d);
                di4_reg <= SW'(di3d);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: num * conj(den) and |den|^2
    // ---------------------------------------------------------------
    logic signed [2*SW-1:0] p_a, p_b, p_c, p_d, p_e, p_f;
    logic signed [XW-1:0]   xr5_reg, xi5_reg;
    logic [XW-1:0]          m5_reg;

    cre_mul #(.AW(SW), .BW(SW)) u_mul_a (.clk(clk), .en(en), .a(nr4_reg), .b(dr4_reg), .p(p_a));
    cre_mul #(.AW(SW), .BW(SW)) u_mul_b (.clk(clk), .en(en), .a(ni4_reg), .b(di4_reg), .p(p_b));
    cre_mul #(.AW(SW), .BW(SW)) u_mul_c (.clk(clk), .en(en), .a(ni4_reg), .b(dr4_reg), .p(p_c));
    cre_mul #(.AW(SW), .BW(SW)) u_mul_d (.clk(clk), .en(en), .a(nr4_reg), .b(di4_reg), .p(p_d));
    cre_mul #(.AW(SW), .BW(SW)) u_mul_e (.clk(clk), .en(en), .a(dr4_reg), .b(dr4_reg), .p(p_e));
    cre_mul #(.AW(SW), .BW(SW)) u_mul_f (.clk(clk), .en(en), .a(di4_reg), .b(di4_reg), .p(p_f));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xr5_reg <= XW'(p_a) + XW'(p_b);
            xi5_reg <= XW'(p_c) - XW'(p_d);
            m5_reg  <= XW'(p_e) + XW'(p_f);
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: rounded quotients, then the output register
    // ---------------------------------------------------------------
    logic [CRE_RES_W-1:0] q_re, q_im;
    logic                 sat_re, sat_im;
    logic [CRE_RES_W-1:0] h_real_reg, h_imag_reg;
    logic                 sat_reg;

    cre_div #(.XW(XW), .FB(RESULT_FRAC_BITS)) u_div_re
    (
        .clk (clk),
        .en  (en),
        .x   (xr5_reg),
        .m   (m5_reg),
        .q   (q_re),
        .sat (sat_re)
    );

    cre_div #(.XW(XW), .FB(RESULT_FRAC_BITS)) u_div_im
    (
        .clk (clk),
        .en  (en),
        .x   (xi5_reg),
        .m   (m5_reg),
        .q   (q_im),
        .sat (sat_im)
    );

    // hold the result while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_real_reg <= q_re;
            h_imag_reg <= q_im;
            sat_reg    <= sat_re || sat_im;
        end
    end

    assign h_real    = h_real_reg;
    assign h_imag    = h_imag_reg;
    assign saturated = sat_reg;

endmodule
